// ===== rtl/tpbs_pkg.sv =====
`timescale 1ns / 1ps

package tpbs_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_START      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_END        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KD_VALUE      = 3'd3;

	localparam logic [10:0] SEGMENT_TICKS_RST = 11'd1500;
	localparam logic [7:0]  KP_START_RST      = 8'd20;
	localparam logic [7:0]  KP_END_RST        = 8'd60;
	localparam logic [7:0]  KD_VALUE_RST      = 8'd5;

	// Script segments.
	localparam logic [2:0] SEG_STAND   = 3'd0;
	localparam logic [2:0] SEG_REAR    = 3'd1;
	localparam logic [2:0] SEG_FRONT   = 3'd2;
	localparam logic [2:0] SEG_PREPARE = 3'd3;
	localparam logic [2:0] SEG_KICK    = 3'd4;
	localparam logic [2:0] SEG_IDLE    = 3'd5;

	// Upper joint bound that means every joint; clipped to the joint count.
	localparam logic [5:0] GROUP_ALL = 6'd32;

	// e^(1/300) - 1 in Q32 from a six-term series, as used to grow the
	// exponential while the phase table is built.
	localparam logic [63:0] EXP_T1  = (64'd1 << 56) / 64'd300;
	localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd600;
	localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd900;
	localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd1200;
	localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd1500;
	localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd1800;
	localparam logic [63:0] EXP_SUM = EXP_T1 + EXP_T2 + EXP_T3 + EXP_T4 + EXP_T5 + EXP_T6;
	localparam logic [23:0] EXP_D   = 24'((EXP_SUM + (64'd1 << 23)) >> 24);

	localparam logic [47:0] EXP_ONE = 48'd1 << 28;
	localparam logic [47:0] EXP_CAP = 48'd1 << 46;
	localparam logic [15:0] PHASE_MAX = 16'd32767;

	localparam int BASE_POSES  = 6;
	localparam int BASE_JOINTS = 12;

	localparam logic signed [15:0] BASE_POSE [BASE_POSES][BASE_JOINTS] = '{
		'{16'sd194, 16'sd5005, -16'sd10010, -16'sd194, 16'sd5005, -16'sd10010,
		  16'sd194, 16'sd5005, -16'sd10010, -16'sd194, 16'sd5005, -16'sd10010},
		'{16'sd23, 16'sd2494, -16'sd4987, -16'sd23, 16'sd2494, -16'sd4987,
		  16'sd23, 16'sd2494, -16'sd4987, -16'sd23, 16'sd2494, -16'sd4987},
		'{16'sd194, 16'sd5005, -16'sd10010, -16'sd807, 16'sd2288, -16'sd3793,
		  -16'sd944, 16'sd3629, -16'sd6605, -16'sd837, 16'sd3953, -16'sd7532},
		'{-16'sd1024, 16'sd6144, 16'sd0, -16'sd807, 16'sd2288, -16'sd3793,
		  -16'sd944, 16'sd3629, -16'sd6605, -16'sd837, 16'sd3953, -16'sd7532},
		'{-16'sd1024, -16'sd6144, -16'sd3277, -16'sd807, 16'sd2288, -16'sd3793,
		  -16'sd944, 16'sd3629, -16'sd6605, -16'sd837, 16'sd3953, -16'sd7532},
		'{16'sd238, -16'sd4772, -16'sd4987, -16'sd807, 16'sd2288, -16'sd3793,
		  -16'sd944, 16'sd3629, -16'sd6605, -16'sd837, 16'sd3953, -16'sd7532}
	};

	function automatic logic signed [15:0] base_pose(input logic [4:0] p, input logic [5:0] j);
		logic signed [15:0] v;
		v = 16'sd0;
		if (p < 5'(BASE_POSES) && j < 6'(BASE_JOINTS)) begin
			v = BASE_POSE[p[2:0]][j[3:0]];
		end
		return v;
	endfunction

	function automatic logic [3:0] seg_dest(input logic [2:0] seg);
		logic [3:0] v;
		case (seg)
			SEG_STAND:   v = 4'd1;
			SEG_REAR:    v = 4'd2;
			SEG_FRONT:   v = 4'd2;
			SEG_PREPARE: v = 4'd3;
			SEG_KICK:    v = 4'd4;
			default:     v = 4'd0;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] seg_org(input logic [2:0] seg);
		logic [3:0] v;
		case (seg)
			SEG_STAND:   v = 4'd0;
			SEG_REAR:    v = 4'd1;
			SEG_FRONT:   v = 4'd1;
			SEG_PREPARE: v = 4'd2;
			SEG_KICK:    v = 4'd2;
			default:     v = 4'd0;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] seg_lo(input logic [2:0] seg);
		logic [5:0] v;
		case (seg)
			SEG_REAR: v = 6'd6;
			SEG_KICK: v = 6'd1;
			default:  v = 6'd0;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] seg_hi(input logic [2:0] seg);
		logic [5:0] v;
		case (seg)
			SEG_STAND:   v = GROUP_ALL;
			SEG_REAR:    v = 6'd12;
			SEG_FRONT:   v = 6'd6;
			SEG_PREPARE: v = 6'd6;
			SEG_KICK:    v = 6'd2;
			default:     v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tpbs_if.sv =====
`timescale 1ns / 1ps

interface tpbs_cmd_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [2:0]         pose_slot;
	logic [3:0]         joint_number;
	logic signed [15:0] angle_value;

	modport source(output valid, func, pose_slot, joint_number, angle_value, input ready);
	modport sink(input valid, func, pose_slot, joint_number, angle_value, output ready);
endinterface

interface tpbs_res_if;
	logic               valid;
	logic               ready;
	logic [3:0]         joint_index;
	logic signed [15:0] joint_angle;
	logic [15:0]        stiffness;
	logic [7:0]         damping;
	logic [2:0]         segment_now;
	logic               last_joint;

	modport source(output valid, joint_index, joint_angle, stiffness, damping, segment_now,
		last_joint, input ready);
	modport sink(input valid, joint_index, joint_angle, stiffness, damping, segment_now,
		last_joint, output ready);
endinterface

interface tpbs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tpbs_pkg::CFG_IDX_W-1:0]  index;
	logic [tpbs_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/tpbs_pose_mem.sv =====
`timescale 1ns / 1ps

module tpbs_pose_mem #(
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic signed [15:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic signed [15:0]       rdata_a,
	output logic signed [15:0]       rdata_b
);

	logic signed [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/tpbs_phase_mem.sv =====
`timescale 1ns / 1ps

module tpbs_phase_mem #(
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [15:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [15:0]              rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tpbs_phase_gen.sv =====
`timescale 1ns / 1ps

// Builds the tanh phase table after reset: entry k is (E-1)/(E+1) in Q0.15,
// where E = e^(k/300) is grown by one multiply-add per entry. Each entry goes
// through a setup step, sixteen restoring divide steps, a multiply of the high and
// then the low half of E on a shared multiplier, and a write.
module tpbs_phase_gen #(
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [15:0]              wr_data,
	output logic                     done
);

	localparam int AW = $clog2(DEPTH);

	localparam logic [2:0] G_START = 3'd0;
	localparam logic [2:0] G_DIV   = 3'd1;
	localparam logic [2:0] G_M1    = 3'd2;
	localparam logic [2:0] G_M2    = 3'd3;
	localparam logic [2:0] G_WR    = 3'd4;
	localparam logic [2:0] G_DONE  = 3'd5;

	logic [2:0]    st_q;
	logic [47:0]   r_q;
	logic [AW-1:0] k_q;
	logic [3:0]    cnt_q;
	logic [63:0]   rem_q;
	logic [63:0]   dsh_q;
	logic [15:0]   quo_q;
	logic [50:0]   hi_q;
	logic [23:0]   lo_q;

	logic [47:0] num;
	logic [47:0] den;
	logic        ge;
	logic [26:0] mop;
	logic [50:0] prod;
	logic [51:0] isum;

	assign num  = r_q - tpbs_pkg::EXP_ONE;
	assign den  = r_q + tpbs_pkg::EXP_ONE;
	assign ge   = rem_q >= dsh_q;
	// The high and low halves of E go through the same multiplier in turn.
	assign mop  = (st_q == G_M1) ? r_q[46:20] : {7'd0, r_q[19:0]};
	assign prod = 51'(mop) * 51'(tpbs_pkg::EXP_D);
	assign isum = 52'(hi_q) + 52'(lo_q) + 52'd2048;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= G_START;
			r_q   <= tpbs_pkg::EXP_ONE;
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				G_START: begin
					cnt_q <= 4'd15;
					st_q  <= G_DIV;
				end
				G_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						st_q <= G_M1;
					end
				end
				G_M1: begin
					st_q <= G_M2;
				end
				G_M2: begin
					st_q <= G_WR;
				end
				G_WR: begin
					if (r_q < tpbs_pkg::EXP_CAP) begin
						r_q <= r_q + 48'(isum[51:12]);
					end
					if (k_q == AW'(DEPTH - 1)) begin
						st_q <= G_DONE;
					end else begin
						k_q  <= k_q + AW'(1);
						st_q <= G_START;
					end
				end
				G_DONE: begin
					st_q <= G_DONE;
				end
				default: begin
					st_q <= G_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			G_START: begin
				rem_q <= 64'({num, 15'd0}) + 64'(den >> 1);
				dsh_q <= {1'b0, den, 15'd0};
				quo_q <= '0;
			end
			G_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[14:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			G_M1: begin
				hi_q <= prod;
			end
			G_M2: begin
				lo_q <= prod[43:20];
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = (st_q == G_WR);
	assign wr_addr = k_q;
	assign wr_data = (quo_q > tpbs_pkg::PHASE_MAX) ? tpbs_pkg::PHASE_MAX : quo_q;
	assign done    = (st_q == G_DONE);

endmodule

// ===== rtl/timed_pose_blend_sequencer_core.sv =====
`timescale 1ns / 1ps
// A tick that moves joints reads its phase and blends the moved joints, then gives a command
// for every joint, one per cycle while results are taken; a tick that moves no joint skips
// the blend and goes straight to its commands. No word is taken until a tick's last command is loaded.
// A pose load is written as it is taken; result stalls hold the commands back. After reset
// the phase table is built and no word is taken until then; configuration writes are taken
// at all times.
module timed_pose_blend_sequencer_core #(
	parameter int NUM_JOINTS        = 12,
	parameter int NUM_POSES         = 8,
	parameter int PHASE_TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	tpbs_cmd_if.sink    cmd,
	tpbs_res_if.source  res,
	tpbs_cfg_if.sink    cfg
);

	localparam int JW    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int SW    = $clog2(NUM_POSES);
	localparam int PDEP  = NUM_POSES * NUM_JOINTS;
	localparam int PAW   = $clog2(PDEP);
	localparam int PHAW  = $clog2(PHASE_TABLE_DEPTH);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PHASE = 3'd2;
	localparam logic [2:0] S_BLEND = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]  state_q;

	logic [10:0] seg_ticks_q;
	logic [7:0]  kp_start_q;
	logic [7:0]  kp_end_q;
	logic [7:0]  kd_q;

	logic [2:0]  seg_q;
	logic [10:0] tick_q;
	logic [7:0]  damp_q;
	logic signed [15:0] held_angle_q [NUM_JOINTS];
	logic [15:0]        held_stiff_q [NUM_JOINTS];

	logic [SW-1:0] pi_slot_q;
	logic [JW-1:0] pi_jnt_q;
	logic          pinit_done_q;

	logic [JW-1:0]  j_q;
	logic [JW-1:0]  e_q;
	logic           iss_q;
	logic [5:0]     hi_q;
	logic [PAW-1:0] dbase_q;
	logic [PAW-1:0] obase_q;
	logic [2:0]     seg_cur_q;
	logic [15:0]    ph_q;
	logic [15:0]    stiff_q;

	logic                v_s1_q;
	logic [JW-1:0]       j_s1_q;
	logic                v_s2_q;
	logic [JW-1:0]       j_s2_q;
	logic signed [32:0]  prod_s2;
	logic signed [15:0]  org_s2;

	logic               res_v_q;
	logic [3:0]         res_jidx_q;
	logic signed [15:0] res_angle_q;
	logic [15:0]        res_stiff_q;
	logic [7:0]         res_damp_q;
	logic [2:0]         res_seg_q;
	logic               res_last_q;

	logic                gen_we;
	logic [PHAW-1:0]     gen_addr;
	logic [15:0]         gen_data;
	logic                gen_done;
	logic [PHAW-1:0]     ph_raddr;
	logic [15:0]         ph_rdata;

	logic               pm_we;
	logic [PAW-1:0]     pm_waddr;
	logic signed [15:0] pm_wdata;
	logic [PAW-1:0]     pm_raddr_a;
	logic [PAW-1:0]     pm_raddr_b;
	logic signed [15:0] pm_rdata_a;
	logic signed [15:0] pm_rdata_b;

	logic        acc;
	logic        tick;
	logic        load_ok;
	logic [5:0]  g_lo;
	logic [5:0]  g_hi_raw;
	logic [5:0]  g_hi;
	logic        g_move;
	logic [11:0] n_next;
	logic        out_load;

	logic signed [8:0]  kdiff;
	logic signed [24:0] kprod;
	logic signed [25:0] ksum;
	logic signed [16:0] adiff;
	logic signed [34:0] asum;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign tick      = acc && !cmd.func;
	assign load_ok   = acc && cmd.func && (32'(cmd.pose_slot) < NUM_POSES)
		&& (32'(cmd.joint_number) < NUM_JOINTS);

	assign cfg.ready = 1'b1;

	// Group of joints that the current segment moves, clipped to the joint count.
	assign g_lo     = tpbs_pkg::seg_lo(seg_q);
	assign g_hi_raw = tpbs_pkg::seg_hi(seg_q);
	assign g_hi     = (g_hi_raw > 6'(NUM_JOINTS)) ? 6'(NUM_JOINTS) : g_hi_raw;
	assign g_move   = (seg_q < tpbs_pkg::SEG_IDLE) && (g_lo < g_hi);

	assign n_next   = {1'b0, tick_q} + 12'd1;
	assign ph_raddr = (32'(n_next) < PHASE_TABLE_DEPTH) ? PHAW'(n_next)
		: PHAW'(PHASE_TABLE_DEPTH - 1);

	assign out_load = (state_q == S_EMIT) && (!res_v_q || res.ready);

	// Pose table writes come from the reset sweep first, then from load words.
	always_comb begin
		if (!pinit_done_q) begin
			pm_we    = 1'b1;
			pm_waddr = PAW'(32'(pi_slot_q) * NUM_JOINTS + 32'(pi_jnt_q));
			pm_wdata = tpbs_pkg::base_pose(5'(pi_slot_q), 6'(pi_jnt_q));
		end else begin
			pm_we    = load_ok;
			pm_waddr = PAW'(32'(cmd.pose_slot) * NUM_JOINTS + 32'(cmd.joint_number));
			pm_wdata = cmd.angle_value;
		end
	end

	assign pm_raddr_a = dbase_q + PAW'(j_q);
	assign pm_raddr_b = obase_q + PAW'(j_q);

	tpbs_phase_gen #(
		.DEPTH(PHASE_TABLE_DEPTH)
	) u_phase_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (gen_we),
		.wr_addr(gen_addr),
		.wr_data(gen_data),
		.done   (gen_done)
	);

	tpbs_phase_mem #(
		.DEPTH(PHASE_TABLE_DEPTH)
	) u_phase_mem (
		.clk  (clk),
		.we   (gen_we),
		.waddr(gen_addr),
		.wdata(gen_data),
		.raddr(ph_raddr),
		.rdata(ph_rdata)
	);

	tpbs_pose_mem #(
		.DEPTH(PDEP)
	) u_pose_mem (
		.clk    (clk),
		.we     (pm_we),
		.waddr  (pm_waddr),
		.wdata  (pm_wdata),
		.raddr_a(pm_raddr_a),
		.raddr_b(pm_raddr_b),
		.rdata_a(pm_rdata_a),
		.rdata_b(pm_rdata_b)
	);

	// Stiffness is shared by all moved joints of a tick:
	// kp_start * 32768 + ph * (kp_end - kp_start), rounded to Q8.8.
	assign kdiff = $signed({1'b0, kp_end_q}) - $signed({1'b0, kp_start_q});
	assign kprod = $signed({1'b0, ph_rdata[14:0]}) * kdiff;
	assign ksum  = 26'(kprod) + $signed(26'({kp_start_q, 15'd0})) + 26'sd64;

	// Angle blend written as org * 32768 + ph * (dest - org) so that one
	// multiplier serves each joint.
	assign adiff = $signed({pm_rdata_a[15], pm_rdata_a}) - $signed({pm_rdata_b[15], pm_rdata_b});
	assign asum  = 35'(prod_s2) + (35'(org_s2) <<< 15) + 35'sd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			seg_ticks_q  <= tpbs_pkg::SEGMENT_TICKS_RST;
			kp_start_q   <= tpbs_pkg::KP_START_RST;
			kp_end_q     <= tpbs_pkg::KP_END_RST;
			kd_q         <= tpbs_pkg::KD_VALUE_RST;
			seg_q        <= tpbs_pkg::SEG_STAND;
			tick_q       <= '0;
			damp_q       <= '0;
			pi_slot_q    <= '0;
			pi_jnt_q     <= '0;
			pinit_done_q <= 1'b0;
			j_q          <= '0;
			e_q          <= '0;
			iss_q        <= 1'b0;
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			res_v_q      <= 1'b0;
			for (int i = 0; i < NUM_JOINTS; i++) begin
				held_angle_q[i] <= '0;
				held_stiff_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					tpbs_pkg::CFG_SEGMENT_TICKS: seg_ticks_q <= cfg.data[10:0];
					tpbs_pkg::CFG_KP_START:      kp_start_q  <= cfg.data[7:0];
					tpbs_pkg::CFG_KP_END:        kp_end_q    <= cfg.data[7:0];
					tpbs_pkg::CFG_KD_VALUE:      kd_q        <= cfg.data[7:0];
					default: begin
					end
				endcase
			end

			if (!pinit_done_q) begin
				if (pi_jnt_q == JW'(NUM_JOINTS - 1)) begin
					pi_jnt_q <= '0;
					if (pi_slot_q == SW'(NUM_POSES - 1)) begin
						pinit_done_q <= 1'b1;
					end else begin
						pi_slot_q <= pi_slot_q + SW'(1);
					end
				end else begin
					pi_jnt_q <= pi_jnt_q + JW'(1);
				end
			end

			v_s1_q <= (state_q == S_BLEND) && iss_q;
			v_s2_q <= v_s1_q;
			if (v_s2_q) begin
				held_angle_q[j_s2_q] <= asum[30:15];
				held_stiff_q[j_s2_q] <= stiff_q;
			end

			if (out_load) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					if (pinit_done_q && gen_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (tick) begin
						e_q <= '0;
						j_q <= JW'(g_lo);
						if (seg_q < tpbs_pkg::SEG_IDLE) begin
							if (n_next >= {1'b0, seg_ticks_q}) begin
								seg_q  <= seg_q + 3'd1;
								tick_q <= '0;
							end else begin
								tick_q <= n_next[10:0];
							end
						end
						if (g_move) begin
							damp_q  <= kd_q;
							state_q <= S_PHASE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_PHASE: begin
					iss_q   <= 1'b1;
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					if (iss_q) begin
						if (6'(j_q) == hi_q - 6'd1) begin
							iss_q <= 1'b0;
						end else begin
							j_q <= j_q + JW'(1);
						end
					end else if (!v_s1_q && !v_s2_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (e_q == JW'(NUM_JOINTS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							e_q <= e_q + JW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			seg_cur_q <= seg_q;
			hi_q      <= g_hi;
			dbase_q   <= PAW'(32'(tpbs_pkg::seg_dest(seg_q)) * NUM_JOINTS);
			obase_q   <= PAW'(32'(tpbs_pkg::seg_org(seg_q)) * NUM_JOINTS);
		end
		if (state_q == S_PHASE) begin
			ph_q    <= ph_rdata;
			stiff_q <= ksum[22:7];
		end
		j_s1_q  <= j_q;
		j_s2_q  <= j_s1_q;
		prod_s2 <= $signed({1'b0, ph_q[14:0]}) * adiff;
		org_s2  <= pm_rdata_b;
		if (out_load) begin
			res_jidx_q  <= 4'(e_q);
			res_angle_q <= held_angle_q[e_q];
			res_stiff_q <= held_stiff_q[e_q];
			res_damp_q  <= damp_q;
			res_seg_q   <= seg_cur_q;
			res_last_q  <= (e_q == JW'(NUM_JOINTS - 1));
		end
	end

	assign res.valid       = res_v_q;
	assign res.joint_index = res_jidx_q;
	assign res.joint_angle = res_angle_q;
	assign res.stiffness   = res_stiff_q;
	assign res.damping     = res_damp_q;
	assign res.segment_now = res_seg_q;
	assign res.last_joint  = res_last_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD     = 20;
	localparam int NUM_JOINTS     = 12;
	localparam int NUM_POSES      = 8;
	localparam int PHASE_DEPTH    = 2048;
	localparam int MAX_GAP        = 18;
	localparam int LONG_STALL     = 300;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DIRECTED_N     = 24;
	localparam int PHASE_N        = 5;
	localparam int CFG_IDX_BITS   = tpbs_pkg::CFG_IDX_W;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// Register indexes past the last register; writes there must change nothing.
	localparam int CFG_STRAY_LO = 4;
	localparam int CFG_STRAY_HI = 7;

	// A phase with this stop segment runs its full budget.
	localparam logic [2:0] NO_STOP = 3'd7;

	localparam logic signed [15:0] ANGLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] ANGLE_MIN = 16'sh8000;
	localparam logic [7:0] KD_AFTER_RESET = 8'd5;

	// Power-up poses: stand-down, stand-up, kick stance, kick prepare, kick go, stable kick.
	localparam logic signed [15:0] REST_POSE [6][12] = '{
		'{194, 5005, -10010, -194, 5005, -10010, 194, 5005, -10010, -194, 5005, -10010},
		'{23, 2494, -4987, -23, 2494, -4987, 23, 2494, -4987, -23, 2494, -4987},
		'{194, 5005, -10010, -807, 2288, -3793, -944, 3629, -6605, -837, 3953, -7532},
		'{-1024, 6144, 0, -807, 2288, -3793, -944, 3629, -6605, -837, 3953, -7532},
		'{-1024, -6144, -3277, -807, 2288, -3793, -944, 3629, -6605, -837, 3953, -7532},
		'{238, -4772, -4987, -807, 2288, -3793, -944, 3629, -6605, -837, 3953, -7532}
	};

	// Per moving segment: target pose, starting pose and the joint range it drives.
	localparam int BLEND_TO    [5] = '{1, 2, 2, 3, 4};
	localparam int BLEND_FROM  [5] = '{0, 1, 1, 2, 2};
	localparam int GROUP_FIRST [5] = '{0, 6, 0, 0, 1};
	localparam int GROUP_END   [5] = '{NUM_JOINTS, 12, 6, 6, 2};

	typedef struct packed {
		logic               func;
		logic [2:0]         slot;
		logic [3:0]         joint;
		logic signed [15:0] angle;
		logic               pinned;
		logic [3:0]         pin_joint;
		logic signed [15:0] pin_angle;
		logic [7:0]         pin_damping;
	} row_t;

	typedef struct packed {
		logic [3:0]         joint_index;
		logic signed [15:0] angle;
		logic [15:0]        stiffness;
		logic [7:0]         damping;
		logic [2:0]         segment_now;
		logic               last_joint;
	} joint_cmd_t;

	typedef struct packed {
		logic [10:0] ticks;
		logic [7:0]  kp_lo;
		logic [7:0]  kp_hi;
		logic [7:0]  kd;
		int          budget;
		logic [2:0]  stop_seg;
		logic        stray;
		logic        squeeze;
	} phase_t;

	localparam row_t TICK_ROW = '{FUNC_TICK, 3'd0, 4'd0, 16'sd0, 1'b0, 4'd0, 16'sd0, 8'd0};

	logic clk = 1'b0;
	logic arst_n;

	tpbs_cmd_if cmd_bus ();
	tpbs_res_if res_bus ();
	tpbs_cfg_if cfg_bus ();

	timed_pose_blend_sequencer_core #(
		.NUM_JOINTS(NUM_JOINTS),
		.NUM_POSES(NUM_POSES),
		.PHASE_TABLE_DEPTH(PHASE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus),
		.cfg(cfg_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mirror of the sequencer state.
	logic signed [15:0] pose_lut [NUM_POSES * NUM_JOINTS];
	logic [15:0]        tanh_lut [PHASE_DEPTH];
	logic signed [15:0] held_angle [NUM_JOINTS];
	logic [15:0]        held_stiffness [NUM_JOINTS];
	logic [7:0]         held_damping;
	logic [2:0]         script_seg;
	logic [10:0]        seg_tick_count;
	logic [10:0]        ticks_cfg;
	logic [7:0]         kp_start_cfg;
	logic [7:0]         kp_end_cfg;
	logic [7:0]         kd_cfg;

	joint_cmd_t owed_cmds [$];

	bit send_steady;
	bit drain_steady;
	bit squeeze_outputs;
	int unsigned fail_count;
	int unsigned cmds_checked;
	int unsigned ticks_taken;
	int unsigned loads_taken;
	int unsigned loads_dropped;
	int unsigned cfg_writes;
	int unsigned quiet_cycles;
	logic [2:0]  deepest_seg;

	function automatic int draw_gap(inout bit steady);
		if ($urandom_range(0, 31) == 0) steady = !steady;
		return steady ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic logic signed [15:0] mix_angle(input logic signed [15:0] dest_a,
			input logic signed [15:0] orig_a, input logic [15:0] ph);
		longint acc;
		acc = longint'(dest_a) * longint'(ph) + longint'(orig_a) * (64'sd32768 - longint'(ph));
		return 16'((acc + 64'sd16384) >>> 15);
	endfunction

	// Applies one accepted word to the mirrored state and returns the commands it causes.
	function automatic int advance_sequencer(input row_t w, output joint_cmd_t burst [NUM_JOINTS]);
		logic [2:0]  seg;
		int unsigned n;
		int unsigned idx;
		int unsigned kp;
		logic [15:0] ph;
		int          hi;
		seg = script_seg;
		if (w.func == FUNC_LOAD) begin
			if (int'(w.slot) < NUM_POSES && int'(w.joint) < NUM_JOINTS) begin
				pose_lut[int'(w.slot) * NUM_JOINTS + int'(w.joint)] = w.angle;
				loads_taken++;
			end else begin
				loads_dropped++;
			end
			return 0;
		end
		ticks_taken++;
		if (seg <= tpbs_pkg::SEG_KICK) begin
			n = 32'(seg_tick_count) + 1;
			idx = n < PHASE_DEPTH ? n : PHASE_DEPTH - 1;
			ph = tanh_lut[idx];
			hi = GROUP_END[seg] < NUM_JOINTS ? GROUP_END[seg] : NUM_JOINTS;
			for (int j = GROUP_FIRST[seg]; j < hi; j++) begin
				held_angle[j] = mix_angle(pose_lut[BLEND_TO[seg] * NUM_JOINTS + j],
					pose_lut[BLEND_FROM[seg] * NUM_JOINTS + j], ph);
				kp = 32'(ph) * 32'(kp_end_cfg) + (32'd32768 - 32'(ph)) * 32'(kp_start_cfg);
				held_stiffness[j] = 16'((kp + 32'd64) >> 7);
				held_damping = kd_cfg;
			end
			if (n >= 32'(ticks_cfg)) begin
				script_seg = seg + 3'd1;
				seg_tick_count = '0;
			end else begin
				seg_tick_count = 11'(n);
			end
		end
		if (script_seg > deepest_seg) deepest_seg = script_seg;
		for (int j = 0; j < NUM_JOINTS; j++) begin
			burst[j] = '{4'(j), held_angle[j], held_stiffness[j], held_damping, seg,
				(j == NUM_JOINTS - 1)};
		end
		return NUM_JOINTS;
	endfunction

	function automatic row_t draw_word();
		row_t r;
		int pick;
		r = TICK_ROW;
		pick = $urandom_range(0, 99);
		r.slot = 3'($urandom);
		r.joint = 4'($urandom);
		r.angle = 16'($urandom);
		if (pick >= 65) begin
			r.func = FUNC_LOAD;
			// A few loads aim past the last joint and must be dropped.
			r.joint = (pick < 93) ? 4'($urandom_range(0, NUM_JOINTS - 1)) : 4'($urandom_range(12, 15));
			case ($urandom_range(0, 11))
				0: r.angle = ANGLE_MAX;
				1: r.angle = ANGLE_MIN;
				2: r.angle = 16'sd0;
				3: r.angle = -16'sd1;
				default: r.angle = 16'($urandom);
			endcase
		end
		return r;
	endfunction

	task automatic send_word(input row_t r);
		joint_cmd_t burst [NUM_JOINTS];
		int gap;
		int count;
		gap = draw_gap(send_steady);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.func         <= r.func;
		cmd_bus.pose_slot    <= r.slot;
		cmd_bus.joint_number <= r.joint;
		cmd_bus.angle_value  <= r.angle;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		count = advance_sequencer(r, burst);
		if (r.pinned) begin
			burst[r.pin_joint].angle = r.pin_angle;
			burst[r.pin_joint].damping = r.pin_damping;
		end
		for (int j = 0; j < count; j++) owed_cmds.push_back(burst[j]);
	endtask

	// Leaves cfg valid high so that back-to-back writes need no extra step.
	task automatic put_reg(input logic [tpbs_pkg::CFG_IDX_W-1:0] idx,
			input logic [tpbs_pkg::CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			tpbs_pkg::CFG_SEGMENT_TICKS: ticks_cfg = value[10:0];
			tpbs_pkg::CFG_KP_START:      kp_start_cfg = value[7:0];
			tpbs_pkg::CFG_KP_END:        kp_end_cfg = value[7:0];
			tpbs_pkg::CFG_KD_VALUE:      kd_cfg = value[7:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (owed_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void match_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : cmd_check
		joint_cmd_t want;
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			cmds_checked++;
			if (owed_cmds.size() == 0) begin
				$error("joint command for joint %0d arrived with none expected",
					res_bus.joint_index);
				fail_count++;
			end else begin
				want = owed_cmds.pop_front();
				match_field("joint_index", 32'(want.joint_index), 32'(res_bus.joint_index));
				match_field("joint_angle", 32'(want.angle), 32'(res_bus.joint_angle));
				match_field("stiffness", 32'(want.stiffness), 32'(res_bus.stiffness));
				match_field("damping", 32'(want.damping), 32'(res_bus.damping));
				match_field("segment_now", 32'(want.segment_now), 32'(res_bus.segment_now));
				match_field("last_joint", 32'(want.last_joint), 32'(res_bus.last_joint));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles, %0d commands still owed", quiet_cycles,
				owed_cmds.size());
			$display("timed_pose_blend_sequencer_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_ready
		int wait_n;
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			// A long hold lets the block fill up and push back on its input.
			if (squeeze_outputs) begin
				res_bus.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				squeeze_outputs = 1'b0;
			end else begin
				wait_n = draw_gap(drain_steady);
				if (wait_n > 0) begin
					res_bus.ready <= 1'b0;
					repeat (wait_n) @(posedge clk);
				end
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		row_t        directed_rows [DIRECTED_N];
		phase_t      phases [PHASE_N];
		logic [63:0] term;
		logic [63:0] series;
		logic [63:0] growth;
		logic [63:0] expo;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] ratio;
		int          sent;

		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.func = FUNC_TICK;
		cmd_bus.pose_slot = '0;
		cmd_bus.joint_number = '0;
		cmd_bus.angle_value = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		fail_count = 0;
		quiet_cycles = 0;

		ticks_cfg = 11'd1500;
		kp_start_cfg = 8'd20;
		kp_end_cfg = 8'd60;
		kd_cfg = KD_AFTER_RESET;
		foreach (pose_lut[i]) pose_lut[i] = '0;
		foreach (REST_POSE[p, j]) pose_lut[p * NUM_JOINTS + j] = REST_POSE[p][j];
		foreach (held_angle[j]) begin
			held_angle[j] = '0;
			held_stiffness[j] = '0;
		end
		held_damping = '0;
		script_seg = tpbs_pkg::SEG_STAND;
		seg_tick_count = '0;
		deepest_seg = tpbs_pkg::SEG_STAND;

		// tanh(k/600) as (E-1)/(E+1), with E = e^(k/300) grown step by step in Q28.
		term = (64'd1 << 56) / 64'd300;
		series = term;
		for (int n = 2; n <= 6; n++) begin
			term = term / (64'd300 * 64'(n));
			series += term;
		end
		growth = (series + (64'd1 << 23)) >> 24;
		expo = 64'd1 << 28;
		for (int k = 0; k < PHASE_DEPTH; k++) begin
			num = expo - (64'd1 << 28);
			den = expo + (64'd1 << 28);
			ratio = ((num << 15) + den / 64'd2) / den;
			tanh_lut[k] = (ratio > 64'd32767) ? 16'd32767 : ratio[15:0];
			if (expo < (64'd1 << 46)) begin
				expo += ((expo >> 20) * growth + (((expo & 64'hFFFFF) * growth) >> 20)
					+ 64'd2048) >> 12;
			end
		end

		// Equal start and target angles blend to themselves whatever the phase, so those
		// ticks carry a typed-in angle; loads past the last joint must leave them alone.
		directed_rows = '{
			TICK_ROW,
			TICK_ROW,
			'{FUNC_LOAD, 3'd0, 4'd0, ANGLE_MAX, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd1, 4'd0, ANGLE_MAX, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_TICK, 3'd0, 4'd0, 16'sd0, 1'b1, 4'd0, ANGLE_MAX, KD_AFTER_RESET},
			'{FUNC_LOAD, 3'd0, 4'd12, ANGLE_MIN, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd7, 4'd15, -16'sd1, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_TICK, 3'd0, 4'd0, 16'sd0, 1'b1, 4'd0, ANGLE_MAX, KD_AFTER_RESET},
			'{FUNC_LOAD, 3'd0, 4'd11, ANGLE_MIN, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd1, 4'd11, ANGLE_MIN, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_TICK, 3'd0, 4'd0, 16'sd0, 1'b1, 4'd11, ANGLE_MIN, KD_AFTER_RESET},
			'{FUNC_LOAD, 3'd0, 4'd5, ANGLE_MIN, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd1, 4'd5, ANGLE_MAX, 1'b0, 4'd0, 16'sd0, 8'd0},
			TICK_ROW,
			'{FUNC_LOAD, 3'd7, 4'd11, 16'sh5555, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd6, 4'd3, 16'sh2AAA, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd5, 4'd6, 16'sd0, 1'b0, 4'd0, 16'sd0, 8'd0},
			TICK_ROW,
			'{FUNC_LOAD, 3'd1, 4'd13, 16'sd1, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_TICK, 3'd0, 4'd0, 16'sd0, 1'b1, 4'd0, ANGLE_MAX, KD_AFTER_RESET},
			'{FUNC_LOAD, 3'd1, 4'd0, 16'sh1000, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd4, 4'd1, ANGLE_MIN, 1'b0, 4'd0, 16'sd0, 8'd0},
			'{FUNC_LOAD, 3'd2, 4'd1, ANGLE_MAX, 1'b0, 4'd0, 16'sd0, 8'd0},
			TICK_ROW
		};

		// The script only moves forward, so each phase stops once it reaches its segment.
		phases = '{
			'{11'd2047, 8'd255, 8'd0, 8'd255, 50, NO_STOP, 1'b1, 1'b0},
			'{11'd0, 8'd0, 8'd255, 8'd0, 20, tpbs_pkg::SEG_REAR, 1'b0, 1'b0},
			'{11'd16, 8'd37, 8'd201, 8'd128, 100, tpbs_pkg::SEG_KICK, 1'b0, 1'b1},
			'{11'd40, 8'd255, 8'd255, 8'd1, 90, tpbs_pkg::SEG_IDLE, 1'b1, 1'b0},
			'{11'd777, 8'd129, 8'd66, 8'd200, 100, NO_STOP, 1'b0, 1'b0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) send_word(directed_rows[i]);
		settle();

		foreach (phases[p]) begin
			put_reg(tpbs_pkg::CFG_SEGMENT_TICKS, {5'($urandom), phases[p].ticks});
			put_reg(tpbs_pkg::CFG_KP_START, {8'($urandom), phases[p].kp_lo});
			put_reg(tpbs_pkg::CFG_KP_END, {8'($urandom), phases[p].kp_hi});
			put_reg(tpbs_pkg::CFG_KD_VALUE, {8'($urandom), phases[p].kd});
			if (phases[p].stray) begin
				put_reg(CFG_IDX_BITS'($urandom_range(CFG_STRAY_LO, CFG_STRAY_HI)), 16'($urandom));
			end
			cfg_bus.valid <= 1'b0;
			squeeze_outputs = phases[p].squeeze;
			sent = 0;
			while (sent < phases[p].budget && script_seg < phases[p].stop_seg) begin
				send_word(draw_word());
				sent++;
			end
			settle();
		end

		$display("covered %0d ticks and %0d pose loads (%0d dropped), %0d joint commands checked",
			ticks_taken, loads_taken, loads_dropped, cmds_checked);
		$display("script reached segment %0d after %0d register writes", deepest_seg, cfg_writes);
		if (fail_count == 0) begin
			$display("timed_pose_blend_sequencer_core regression: pass");
		end else begin
			$display("timed_pose_blend_sequencer_core regression: fail");
		end
		$finish;
	end

endmodule
